### sv/psa_pkg.sv
// Package for the postfix stack ALU: operation and status codes, item types,
// controller state encoding and size constants.
// No dependencies.
package psa_pkg;

	localparam int PSA_DEPTH   = 64;
	localparam int DATA_W      = 32;
	localparam int IDX_W       = 6;
	localparam int DEPTH_OUT_W = 7;
	localparam int STEP_W      = $clog2(DATA_W);

	localparam logic [2:0] OP_PUSH   = 3'd0;
	localparam logic [2:0] OP_POP    = 3'd1;
	localparam logic [2:0] OP_PEEK_T = 3'd2;
	localparam logic [2:0] OP_PEEK_B = 3'd3;
	localparam logic [2:0] OP_ADD    = 3'd4;
	localparam logic [2:0] OP_SUB    = 3'd5;
	localparam logic [2:0] OP_MUL    = 3'd6;
	localparam logic [2:0] OP_DIV    = 3'd7;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_EMPTY   = 3'd1;
	localparam logic [2:0] ST_RANGE   = 3'd2;
	localparam logic [2:0] ST_FEW     = 3'd3;
	localparam logic [2:0] ST_DIVZERO = 3'd4;
	localparam logic [2:0] ST_FULL    = 3'd5;

	typedef struct packed {
		logic [2:0]               operation;
		logic signed [DATA_W-1:0] operand_value;
		logic [IDX_W-1:0]         peek_index;
	} psa_cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		logic [2:0]               status;
		logic [DEPTH_OUT_W-1:0]   stack_depth;
	} psa_rsp_t;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RD   = 6'b000010,
		S_TOP  = 6'b000100,
		S_SEC  = 6'b001000,
		S_DIV  = 6'b010000,
		S_FIN  = 6'b100000
	} psa_state_t;

endpackage

### sv/postfix_stack_alu_unit.sv
// Top level of the postfix stack ALU: stack memory, entry counter, controller
// and a one-bit-per-cycle restoring divider.
// Depends on psa_pkg.
//
// Timing for the user: an item is taken when start is high and busy is low;
// its single result appears on rsp, flagged by done for exactly one cycle,
// and cannot be held off. Push and every error found from the entry count
// alone (full, empty, index out of range, too few operands) answer straight
// from the idle state and leave busy low. Pop and both peeks answer after
// one stack memory read. Add, subtract and multiply read the top and the
// second-from-top entries one after the other through the single read port.
// Divide by zero is reported after those same two reads; a real divide then
// runs the 32-step divider, retiring one quotient bit per cycle. The stack
// lives in one synchronous memory of DEPTH words with one write and one
// read port; no clearing pass is needed because only entries below the
// entry count are ever read.
module postfix_stack_alu_unit
	import psa_pkg::*;
#(
	parameter int DEPTH = PSA_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  psa_cmd_t cmd,
	output logic     done,
	output psa_rsp_t rsp
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

	// Stack memory, entry 0 at the bottom
	logic [DATA_W-1:0] stack_mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic              wr_en;

	// Control state
	psa_state_t        state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic              done_q, done_d;
	logic [STEP_W-1:0] step_q, step_d;

	// Payload registers
	psa_rsp_t          rsp_q, rsp_d;
	logic [2:0]        op_q, op_d;
	logic [DATA_W-1:0] right_q, right_d;
	logic [DATA_W:0]   rem_q, rem_d;
	logic [DATA_W-1:0] quo_q, quo_d;
	logic [DATA_W-1:0] dvs_q, dvs_d;
	logic              neg_q, neg_d;

	// Working signals
	logic              accept;
	logic [CMPW-1:0]   idx_w;
	logic [CMPW-1:0]   cnt_w;
	logic [CMPW-1:0]   top_pos;
	logic [DATA_W-1:0] left;
	logic [DATA_W-1:0] alu_res;
	logic [DATA_W-1:0] prod;
	logic [DATA_W-1:0] abs_l;
	logic [DATA_W-1:0] abs_r;
	logic [DATA_W:0]   rem_sh;
	logic [DATA_W:0]   rem_try;
	logic [DATA_W-1:0] q_adj;
	logic [DATA_W-1:0] div_res;

	assign accept  = start && !busy;
	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign rsp     = rsp_q;

	assign idx_w   = CMPW'(cmd.peek_index);
	assign cnt_w   = CMPW'(count_q);
	assign top_pos = cnt_w - CMPW'(1) - idx_w;

	// Second-from-top arrives from memory while the top sits in right_q
	assign left    = rd_data_q;
	// Only the low word of the product is kept, so it wraps like the sum
	assign prod    = left * right_q;
	assign abs_l   = left[DATA_W-1] ? (DATA_W'(0) - left) : left;
	assign abs_r   = right_q[DATA_W-1] ? (DATA_W'(0) - right_q) : right_q;

	// Restoring divide step: shift in the next dividend bit, trial subtract
	assign rem_sh  = {rem_q[DATA_W-1:0], quo_q[DATA_W-1]};
	assign rem_try = rem_sh - {1'b0, dvs_q};

	// Floor correction: bump magnitude on a nonzero remainder only when signs differ
	assign q_adj   = quo_q + DATA_W'(rem_q != '0);
	assign div_res = neg_q ? (DATA_W'(0) - q_adj) : quo_q;

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		done_d   = 1'b0;
		step_d   = step_q;
		rsp_d    = rsp_q;
		op_d     = op_q;
		right_d  = right_q;
		rem_d    = rem_q;
		quo_d    = quo_q;
		dvs_d    = dvs_q;
		neg_d    = neg_q;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = '0;
		alu_res  = '0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_d  = cmd.operation;
					rsp_d = '0;
					rsp_d.stack_depth = DEPTH_OUT_W'(count_q);
					case (cmd.operation)
						OP_PUSH: begin
							done_d = 1'b1;
							if (count_q == CW'(DEPTH)) begin
								rsp_d.status = ST_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = AW'(count_q);
								wr_data = cmd.operand_value;
								count_d = count_q + CW'(1);
								rsp_d.result_value = cmd.operand_value;
								rsp_d.stack_depth  = DEPTH_OUT_W'(count_d);
							end
						end
						OP_POP: begin
							if (count_q == '0) begin
								done_d       = 1'b1;
								rsp_d.status = ST_EMPTY;
							end else begin
								rd_addr = AW'(count_q - CW'(1));
								state_d = S_RD;
							end
						end
						OP_PEEK_T, OP_PEEK_B: begin
							if (idx_w >= cnt_w) begin
								done_d       = 1'b1;
								rsp_d.status = ST_RANGE;
							end else begin
								rd_addr = (cmd.operation == OP_PEEK_T) ? AW'(top_pos)
								                                      : AW'(idx_w);
								state_d = S_RD;
							end
						end
						default: begin
							if (count_q < CW'(2)) begin
								done_d       = 1'b1;
								rsp_d.status = ST_FEW;
							end else begin
								rd_addr = AW'(count_q - CW'(1));
								state_d = S_TOP;
							end
						end
					endcase
				end
			end

			S_RD: begin
				// Read data is here; a pop drops the top entry now
				if (op_q == OP_POP) begin
					count_d = count_q - CW'(1);
				end
				rsp_d.result_value = rd_data_q;
				rsp_d.status       = ST_OK;
				rsp_d.stack_depth  = DEPTH_OUT_W'(count_d);
				done_d  = 1'b1;
				state_d = S_IDLE;
			end

			S_TOP: begin
				// Hold the right operand, fetch the left one
				right_d = rd_data_q;
				rd_addr = AW'(count_q - CW'(2));
				state_d = S_SEC;
			end

			S_SEC: begin
				if (op_q == OP_DIV) begin
					if (right_q == '0) begin
						rsp_d.result_value = '0;
						rsp_d.status       = ST_DIVZERO;
						rsp_d.stack_depth  = DEPTH_OUT_W'(count_q);
						done_d  = 1'b1;
						state_d = S_IDLE;
					end else begin
						rem_d   = '0;
						quo_d   = abs_l;
						dvs_d   = abs_r;
						neg_d   = left[DATA_W-1] ^ right_q[DATA_W-1];
						step_d  = '0;
						state_d = S_DIV;
					end
				end else begin
					case (op_q)
						OP_ADD:  alu_res = left + right_q;
						OP_SUB:  alu_res = left - right_q;
						default: alu_res = prod;
					endcase
					wr_en   = 1'b1;
					wr_addr = AW'(count_q - CW'(2));
					wr_data = alu_res;
					count_d = count_q - CW'(1);
					rsp_d.result_value = alu_res;
					rsp_d.status       = ST_OK;
					rsp_d.stack_depth  = DEPTH_OUT_W'(count_d);
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end

			S_DIV: begin
				if (!rem_try[DATA_W]) begin
					rem_d = rem_try;
					quo_d = {quo_q[DATA_W-2:0], 1'b1};
				end else begin
					rem_d = rem_sh;
					quo_d = {quo_q[DATA_W-2:0], 1'b0};
				end
				step_d = step_q + STEP_W'(1);
				if (step_q == '1) begin
					state_d = S_FIN;
				end
			end

			S_FIN: begin
				// Write the quotient over the left operand and drop the top
				wr_en   = 1'b1;
				wr_addr = AW'(count_q - CW'(2));
				wr_data = div_res;
				count_d = count_q - CW'(1);
				rsp_d.result_value = div_res;
				rsp_d.status       = ST_OK;
				rsp_d.stack_depth  = DEPTH_OUT_W'(count_d);
				done_d  = 1'b1;
				state_d = S_IDLE;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Stack memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= stack_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
			step_q  <= step_d;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q   <= rsp_d;
		op_q    <= op_d;
		right_q <= right_d;
		rem_q   <= rem_d;
		quo_q   <= quo_d;
		dvs_q   <= dvs_d;
		neg_q   <= neg_d;
	end

endmodule

### sv/psa_checker.sv
// Port-level checker for the postfix stack ALU, bound to the top level.
// Depends on psa_pkg and postfix_stack_alu_unit.
module psa_checker
	import psa_pkg::*;
#(
	parameter int DEPTH = PSA_DEPTH
) (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input psa_cmd_t cmd,
	input logic     done,
	input psa_rsp_t rsp
);

	// An accepted item either answers at once or holds the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done || busy)
		else $error("accepted item neither answered nor held busy");

	// Busy drops only together with the result of the item in flight
	a_busy_release: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy released without a result");

	// Errors carry a zero value
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != ST_OK |-> rsp.result_value == '0)
		else $error("error result with nonzero value");

	// A full report can only come from a full stack
	a_full_depth: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == ST_FULL |-> rsp.stack_depth == DEPTH_OUT_W'(DEPTH))
		else $error("full reported at wrong depth");

endmodule

bind postfix_stack_alu_unit psa_checker #(.DEPTH(DEPTH)) u_psa_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.rsp    (rsp)
);

### tb/psa_stack_checker.sv
`timescale 1ns / 100ps
// Checker for the postfix stack ALU: watches the item and result channels,
// predicts each result from its own operand stack and compares field by field.
// Depends on psa_pkg.
module psa_stack_checker
	import psa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  psa_cmd_t    cmd,
	input  logic        done,
	input  psa_rsp_t    rsp,
	output int unsigned waiting,
	output int          fail_count
);

	logic signed [DATA_W-1:0] stack_mem [PSA_DEPTH];
	int                       entries;
	psa_rsp_t                 expected_rsp_q [$];

	task automatic report_mismatch(input string msg);
		$display("%0t ns  mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// Apply one item to the local stack and return the result it must give.
	function automatic psa_rsp_t step_stack(input psa_cmd_t c);
		psa_rsp_t                 r;
		logic signed [DATA_W-1:0] lhs;
		logic signed [DATA_W-1:0] rhs;
		logic signed [DATA_W-1:0] outcome;
		longint                   tq;
		longint                   tr;
		r = '0;
		r.status = ST_OK;
		case (c.operation)
			OP_PUSH: begin
				if (entries >= PSA_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					stack_mem[entries] = c.operand_value;
					entries++;
					r.result_value = c.operand_value;
				end
			end
			OP_POP: begin
				if (entries == 0) begin
					r.status = ST_EMPTY;
				end else begin
					entries--;
					r.result_value = stack_mem[entries];
				end
			end
			OP_PEEK_T: begin
				if (int'(c.peek_index) >= entries) r.status = ST_RANGE;
				else r.result_value = stack_mem[entries - 1 - int'(c.peek_index)];
			end
			OP_PEEK_B: begin
				if (int'(c.peek_index) >= entries) r.status = ST_RANGE;
				else r.result_value = stack_mem[c.peek_index];
			end
			default: begin
				if (entries < 2) begin
					r.status = ST_FEW;
				end else begin
					rhs = stack_mem[entries - 1];
					lhs = stack_mem[entries - 2];
					if (c.operation == OP_DIV && rhs == 0) begin
						r.status = ST_DIVZERO;
					end else begin
						case (c.operation)
							OP_ADD: outcome = lhs + rhs;
							OP_SUB: outcome = lhs - rhs;
							OP_MUL: outcome = lhs * rhs;
							default: begin
								// floor: step the truncated quotient down on a
								// remainder with opposite signs
								tq = longint'(lhs) / longint'(rhs);
								tr = longint'(lhs) % longint'(rhs);
								if (tr != 0 && ((lhs < 0) != (rhs < 0))) tq--;
								outcome = tq[DATA_W-1:0];
							end
						endcase
						entries--;
						stack_mem[entries - 1] = outcome;
						r.result_value = outcome;
					end
				end
			end
		endcase
		r.stack_depth = DEPTH_OUT_W'(entries);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		psa_rsp_t want;
		if (!arst_n) begin
			entries = 0;
			expected_rsp_q.delete();
			fail_count = 0;
			waiting <= 0;
		end else begin
			if ($isunknown({busy, done})) report_mismatch("busy or done unknown");
			// queue first, so a result in the acceptance cycle still lines up
			if (start && !busy) expected_rsp_q.push_back(step_stack(cmd));
			if (done) begin
				if (expected_rsp_q.size() == 0) begin
					report_mismatch("result with no item outstanding");
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.result_value !== want.result_value)
						report_mismatch($sformatf("result_value %0d, want %0d",
							rsp.result_value, want.result_value));
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d",
							rsp.status, want.status));
					if (rsp.stack_depth !== want.stack_depth)
						report_mismatch($sformatf("stack_depth %0d, want %0d",
							rsp.stack_depth, want.stack_depth));
				end
			end
			waiting <= expected_rsp_q.size();
		end
	end

endmodule

### tb/tb_postfix_stack_alu_unit.sv
`timescale 1ns / 100ps
// Testbench top for postfix_stack_alu_unit: drives items, pauses the sender
// and gives the verdict. Depends on psa_pkg, postfix_stack_alu_unit and psa_stack_checker.
module tb_postfix_stack_alu_unit
	import psa_pkg::*;
();

	localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        done;
	psa_cmd_t    cmd = '0;
	psa_rsp_t    rsp;
	int unsigned waiting;
	int          fail_count;
	int unsigned idle_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	postfix_stack_alu_unit dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.done  (done),
		.rsp   (rsp)
	);

	// The checker sits beside the block and sees exactly what it sees.
	psa_stack_checker stack_watch (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.rsp       (rsp),
		.waiting   (waiting),
		.fail_count(fail_count)
	);

	function automatic psa_cmd_t make_item(input logic [2:0] op,
		input logic signed [DATA_W-1:0] val, input logic [IDX_W-1:0] idx);
		psa_cmd_t c;
		c.operation     = op;
		c.operand_value = val;
		c.peek_index    = idx;
		return c;
	endfunction

	// Operand mix: extremes, small values (so divides leave remainders and
	// hit zero divisors now and then), and fully random words.
	function automatic logic signed [DATA_W-1:0] pick_operand();
		case ($urandom_range(3))
			0: begin
				case ($urandom_range(4))
					0: return MOST_NEG;
					1: return MOST_POS;
					2: return 0;
					3: return -1;
					default: return 1;
				endcase
			end
			1: return DATA_W'(int'($urandom_range(40)) - 20);
			default: return $urandom();
		endcase
	endfunction

	// push_pct steers the stack towards full, towards empty, or holds it level.
	function automatic psa_cmd_t pick_item(input int unsigned push_pct);
		psa_cmd_t c;
		c.operand_value = pick_operand();
		c.peek_index    = ($urandom_range(3) == 0) ? IDX_W'($urandom_range(63))
		                                           : IDX_W'($urandom_range(7));
		if ($urandom_range(99) < push_pct) c.operation = OP_PUSH;
		else c.operation = 3'($urandom_range(OP_DIV, OP_POP));
		return c;
	endfunction

	// Hold start low for the random gap, then present the item and hold it
	// until the block takes it. Start is left high, so back-to-back items
	// never lower and raise it in one step.
	task automatic issue(input psa_cmd_t c);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
	endtask

	// Drop start and wait until every result owed has come back.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
	endtask

	initial begin
		psa_cmd_t    directed [$];
		int unsigned push_pct;
		int unsigned run_left;
		idle_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: errors on an empty stack, too few operands, divide by zero,
		// wrap on multiply, most negative over minus one, floor rounding.
		directed = {
			make_item(OP_POP,    0, 0),
			make_item(OP_PEEK_T, 0, 0),
			make_item(OP_PEEK_B, 0, 63),
			make_item(OP_ADD,    0, 0),
			make_item(OP_PUSH,   MOST_POS, 63),
			make_item(OP_DIV,    0, 0),
			make_item(OP_PUSH,   MOST_NEG, 0),
			make_item(OP_PEEK_T, -1, 1),
			make_item(OP_PEEK_B, 0, 1),
			make_item(OP_PEEK_T, 0, 2),
			make_item(OP_ADD,    0, 0),
			make_item(OP_PUSH,   0, 0),
			make_item(OP_DIV,    0, 0),
			make_item(OP_POP,    0, 0),
			make_item(OP_PUSH,   MOST_NEG, 0),
			make_item(OP_PUSH,   -1, 0),
			make_item(OP_DIV,    0, 0),
			make_item(OP_PUSH,   7, 0),
			make_item(OP_PUSH,   -2, 0),
			make_item(OP_DIV,    0, 0),
			make_item(OP_MUL,    0, 0),
			make_item(OP_PUSH,   -7, 0),
			make_item(OP_PUSH,   -2, 0),
			make_item(OP_DIV,    0, 0),
			make_item(OP_SUB,    0, 0)
		};
		foreach (directed[i]) issue(directed[i]);
		drain();

		// Random: three phases of sender idling (light, heavy, none), each in
		// runs that fill the stack to full, empty it, or keep it level.
		push_pct = 45;
		run_left = 0;
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 33 : (phase == 1) ? 84 : 0;
			for (int n = 0; n < 460; n++) begin
				if (run_left == 0) begin
					case ($urandom_range(2))
						0: push_pct = 85;
						1: push_pct = 15;
						default: push_pct = 45;
					endcase
					run_left = $urandom_range(160, 40);
				end
				run_left--;
				issue(pick_item(push_pct));
			end
			drain();
		end

		// Let any trailing strobe show, about one divide's worth.
		repeat (40) @(posedge clk);
		if (fail_count == 0 && waiting == 0) begin
			$display("** postfix_stack_alu_unit: PASSED **");
		end else begin
			$display("** postfix_stack_alu_unit: FAILED **");
		end
		$finish;
	end

	// Hard stop: several times the slowest correct run.
	initial begin
		#(5_000_000);
		$display("** postfix_stack_alu_unit: FAILED **");
		$finish;
	end

endmodule
